/* src/cbc_pkg.sv */
// shared types and constants of the cartridge bank controller
`default_nettype none
package cbc_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_MBC1,
    KIND_MBC2,
    KIND_MBC3,
    KIND_MBC5
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_ACC,
    ST_DONE
  } fsm_t;

  localparam logic [1:0] MODE_ROM_RD = 2'd0;
  localparam logic [1:0] MODE_MAP_WR = 2'd1;
  localparam logic [1:0] MODE_RAM_RD = 2'd2;
  localparam logic [1:0] MODE_RAM_WR = 2'd3;

  localparam logic [1:0] CFG_CART_TYPE = 2'd0;
  localparam logic [1:0] CFG_ROM_BANKS = 2'd1;
  localparam logic [1:0] CFG_ROM_IMAGE = 2'd2;
  localparam logic [1:0] CFG_RAM_BYTES = 2'd3;

  localparam logic [9:0]  ROM_BANKS_MAX  = 10'd512;
  localparam logic [23:0] ROM_IMAGE_MAX  = 24'd8388608;
  localparam logic [17:0] MBC2_RAM_BYTES = 18'd512;

  localparam int DVD_W      = 9;
  localparam int DVS_W      = 10;
  localparam int STEP_BITS  = 3;
  localparam int MOD_STEPS  = DVD_W / STEP_BITS;
  localparam int CNT_W      = $clog2(MOD_STEPS);

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  rom_banks;
    logic [23:0] image_len;
    logic [17:0] ram_size;
    logic        ram_enabled;
    logic [4:0]  mbc1_low_bank;
    logic [1:0]  mbc1_high_bits;
    logic        mbc1_mode;
    logic [3:0]  mbc2_bank;
    logic [6:0]  mbc3_rom_bank;
    logic [3:0]  mbc3_ram_bank;
    logic [8:0]  mbc5_rom_bank;
    logic [3:0]  mbc5_ram_bank;
  } cbc_bank_t;

  typedef struct packed {
    logic        en;
    logic [15:0] address;
    logic [7:0]  value;
  } cbc_map_wr_t;

  function automatic kind_t decode_kind(input logic [7:0] t);
    kind_t k;
    k = KIND_NONE;
    if (t >= 8'h01 && t <= 8'h03) k = KIND_MBC1;
    if (t == 8'h05 || t == 8'h06) k = KIND_MBC2;
    if (t >= 8'h0F && t <= 8'h13) k = KIND_MBC3;
    if (t >= 8'h19 && t <= 8'h1E) k = KIND_MBC5;
    return k;
  endfunction

endpackage
`default_nettype wire

/* src/cbc_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

/* src/cbc_mod.sv */
// multi-cycle remainder unit for bank numbers, three bits per cycle
`default_nettype none
module cbc_mod import cbc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic      [DVS_W-1:0] remainder
);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem_next;
  logic [DVD_W-1:0] dvd_next;

  always_comb begin
    rem_next = remainder;
    dvd_next = dvd;
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_next = {rem_next[DVS_W-2:0], dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (rem_next >= dvs) begin
        rem_next = rem_next - dvs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(MOD_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd_next;
      remainder <= rem_next;
    end
  end

endmodule
`default_nettype wire

/* src/cbc_map.sv */
// configuration registers and mapper bank registers
`default_nettype none
module cbc_map import cbc_pkg::*; #(
  parameter int RAM_BYTES = 131072
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire cbc_map_wr_t wr,
  output cbc_bank_t        bank
);

  logic [7:0]  cart_type;
  logic [9:0]  rom_bank_count;
  logic [23:0] rom_image_bytes;
  logic [17:0] ram_bytes;
  logic        ram_enabled;
  logic [4:0]  mbc1_low_bank;
  logic [1:0]  mbc1_high_bits;
  logic        mbc1_mode;
  logic [3:0]  mbc2_bank;
  logic [6:0]  mbc3_rom_bank;
  logic [3:0]  mbc3_ram_bank;
  logic [8:0]  mbc5_rom_bank;
  logic [3:0]  mbc5_ram_bank;
  kind_t       kind;

  assign kind = decode_kind(cart_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type       <= 8'd0;
      rom_bank_count  <= 10'd2;
      rom_image_bytes <= 24'd32768;
      ram_bytes       <= 18'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CART_TYPE: cart_type       <= cfg_data[7:0];
        CFG_ROM_BANKS: rom_bank_count  <= cfg_data[9:0];
        CFG_ROM_IMAGE: rom_image_bytes <= cfg_data;
        CFG_RAM_BYTES: ram_bytes       <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled    <= 1'b0;
      mbc1_low_bank  <= 5'd1;
      mbc1_high_bits <= 2'd0;
      mbc1_mode      <= 1'b0;
      mbc2_bank      <= 4'd1;
      mbc3_rom_bank  <= 7'd1;
      mbc3_ram_bank  <= 4'd0;
      mbc5_rom_bank  <= 9'd1;
      mbc5_ram_bank  <= 4'd0;
    end else if (wr.en && kind != KIND_NONE && !wr.address[15]) begin
      if (kind == KIND_MBC2) begin
        if (!wr.address[14]) begin
          if (!wr.address[8]) begin
            ram_enabled <= (wr.value[3:0] == 4'hA);
          end else begin
            mbc2_bank <= (wr.value[3:0] == 4'd0) ? 4'd1 : wr.value[3:0];
          end
        end
      end else begin
        case (wr.address[14:13])
          2'b00: begin
            ram_enabled <= (wr.value[3:0] == 4'hA);
          end
          2'b01: begin
            if (kind == KIND_MBC1) begin
              mbc1_low_bank <= (wr.value[4:0] == 5'd0) ? 5'd1 : wr.value[4:0];
            end else if (kind == KIND_MBC3) begin
              mbc3_rom_bank <= (wr.value[6:0] == 7'd0) ? 7'd1 : wr.value[6:0];
            end else if (!wr.address[12]) begin
              mbc5_rom_bank[7:0] <= wr.value;
            end else begin
              mbc5_rom_bank[8] <= wr.value[0];
            end
          end
          2'b10: begin
            if (kind == KIND_MBC1) begin
              mbc1_high_bits <= wr.value[1:0];
            end else if (kind == KIND_MBC3) begin
              mbc3_ram_bank <= wr.value[3:0];
            end else begin
              mbc5_ram_bank <= wr.value[3:0];
            end
          end
          default: begin
            if (kind == KIND_MBC1) begin
              mbc1_mode <= wr.value[0];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    bank.kind           = kind;
    bank.rom_banks      = (rom_bank_count > ROM_BANKS_MAX) ? ROM_BANKS_MAX : rom_bank_count;
    bank.image_len      = (rom_image_bytes > ROM_IMAGE_MAX) ? ROM_IMAGE_MAX : rom_image_bytes;
    if (kind == KIND_MBC2) begin
      bank.ram_size = MBC2_RAM_BYTES;
    end else if (ram_bytes > 18'(RAM_BYTES)) begin
      bank.ram_size = 18'(RAM_BYTES);
    end else begin
      bank.ram_size = ram_bytes;
    end
    bank.ram_enabled    = ram_enabled;
    bank.mbc1_low_bank  = mbc1_low_bank;
    bank.mbc1_high_bits = mbc1_high_bits;
    bank.mbc1_mode      = mbc1_mode;
    bank.mbc2_bank      = mbc2_bank;
    bank.mbc3_rom_bank  = mbc3_rom_bank;
    bank.mbc3_ram_bank  = mbc3_ram_bank;
    bank.mbc5_rom_bank  = mbc5_rom_bank;
    bank.mbc5_ram_bank  = mbc5_ram_bank;
  end

endmodule
`default_nettype wire

/* src/cartridge_bank_controller.sv */
// top level of the cartridge bank controller
//
//   channel  signals                                   direction
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in
//   req      req_valid/req_stall, mode, address, value in
//   rsp      rsp_valid/rsp_stall, read_data, rom_fetch,
//            rom_address, ram_dirty                    out
//
// a request passes from ST_IDLE through ST_MOD (the shared bank remainder unit)
// and ST_ACC (the ram access) to ST_DONE, which loads the output register; the
// next request is taken only back in ST_IDLE. after reset a clearing pass zeroes
// the external ram, during which req_stall is high; cfg writes are taken at any time.
// a result waiting under rsp_stall holds the next word before its output.
`default_nettype none
module cartridge_bank_controller import cbc_pkg::*; #(
  parameter int RAM_BYTES = 131072
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  value,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [7:0]       read_data,
  output logic             rom_fetch,
  output logic [22:0]      rom_address,
  output logic             ram_dirty
);

  localparam int RA_W = $clog2(RAM_BYTES);

  fsm_t            state;
  fsm_t            state_next;
  cbc_bank_t       bank;
  cbc_map_wr_t     map_wr;
  logic [1:0]      op_mode;
  logic [15:0]     op_addr;
  logic [7:0]      op_value;
  logic [RA_W-1:0] clr_addr;
  logic            dirty;
  logic            accept;
  logic            div_busy;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVS_W-1:0] rem;
  logic [4:0]      ram_n;
  logic [4:0]      req_ram_n;
  logic [8:0]      sw_raw;
  logic [8:0]      rom_bank;
  logic [22:0]     rom_r;
  logic            rom_hit;
  logic [3:0]      ram_bank;
  logic            ram_miss;
  logic [17:0]     ram_r;
  logic            ram_hit;
  logic            ram_en;
  logic            ram_we;
  logic [RA_W-1:0] ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;
  logic            pend_ram_rd;
  logic            pend_mbc2;
  logic [7:0]      pend_data;
  logic            pend_fetch;
  logic [22:0]     pend_addr;
  logic            load;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;

  cbc_map #(.RAM_BYTES(RAM_BYTES)) u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (map_wr),
    .bank      (bank)
  );

  // remainder operands, picked from the bank registers by the request's mode and address
  assign req_ram_n = bank.ram_size[17:13];

  always_comb begin
    case (bank.kind)
      KIND_MBC5: sw_raw = bank.mbc5_rom_bank;
      KIND_MBC3: sw_raw = {2'b00, bank.mbc3_rom_bank};
      KIND_MBC2: sw_raw = {5'b00000, bank.mbc2_bank};
      default:   sw_raw = {2'b00, bank.mbc1_high_bits, bank.mbc1_low_bank};
    endcase
    if (mode == MODE_RAM_RD || mode == MODE_RAM_WR) begin
      div_divisor = {5'b00000, req_ram_n};
      if (bank.kind == KIND_MBC5) begin
        div_dividend = {5'b00000, bank.mbc5_ram_bank};
      end else begin
        div_dividend = {7'b0000000, bank.mbc1_high_bits};
      end
    end else begin
      div_divisor = bank.rom_banks;
      if (address[14]) begin
        div_dividend = sw_raw;
      end else begin
        div_dividend = {2'b00, bank.mbc1_high_bits, 5'b00000};
      end
    end
  end

  cbc_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= mode;
      op_addr  <= address;
      op_value <= value;
    end
  end

  // rom translation
  always_comb begin
    if (bank.kind == KIND_MBC5) begin
      rom_bank = (bank.rom_banks == 10'd0) ? 9'd0 : rem[8:0];
    end else if (bank.rom_banks == 10'd0 || rem == 10'd0) begin
      rom_bank = 9'd1;
    end else begin
      rom_bank = rem[8:0];
    end
    if (bank.kind == KIND_NONE || op_addr[15]) begin
      rom_r = {7'd0, op_addr};
    end else if (op_addr[14]) begin
      rom_r = {rom_bank, op_addr[13:0]};
    end else if (bank.kind == KIND_MBC1 && bank.mbc1_mode && bank.rom_banks != 10'd0) begin
      rom_r = {rem[8:0], op_addr[13:0]};
    end else begin
      rom_r = {9'd0, op_addr[13:0]};
    end
    rom_hit = {1'b0, rom_r} < bank.image_len;
  end

  // external ram offset
  assign ram_n = bank.ram_size[17:13];

  always_comb begin
    ram_miss = 1'b0;
    ram_bank = 4'd0;
    case (bank.kind)
      KIND_MBC3: begin
        ram_bank = bank.mbc3_ram_bank;
        ram_miss = bank.mbc3_ram_bank > 4'd3;
      end
      KIND_MBC5: begin
        ram_bank = (ram_n == 5'd0) ? 4'd0 : rem[3:0];
      end
      KIND_MBC1: begin
        if (bank.mbc1_mode && ram_n != 5'd0) begin
          ram_bank = rem[3:0];
        end
      end
      default: ;
    endcase
    if (bank.kind == KIND_MBC2) begin
      ram_r = {9'd0, op_addr[8:0]};
    end else begin
      ram_r = {1'b0, ram_bank, op_addr[12:0]};
    end
    ram_hit = bank.ram_enabled && bank.ram_size != 18'd0 && op_addr[15:13] == 3'b101
              && !ram_miss && ram_r < bank.ram_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      dirty    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_ACC && op_mode == MODE_RAM_WR && ram_hit) begin
        dirty <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next    = state;
    req_stall     = 1'b1;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = ram_r[RA_W-1:0];
    ram_wdata     = (bank.kind == KIND_MBC2) ? {4'h0, op_value[3:0]} : op_value;
    map_wr.en     = 1'b0;
    map_wr.address = op_addr;
    map_wr.value  = op_value;
    load          = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = 8'h00;
        if (clr_addr == RA_W'(RAM_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!div_busy) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        map_wr.en  = (op_mode == MODE_MAP_WR);
        ram_en     = ram_hit && (op_mode == MODE_RAM_RD || op_mode == MODE_RAM_WR);
        ram_we     = (op_mode == MODE_RAM_WR);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  cbc_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (state == ST_ACC) begin
      pend_mbc2   <= (bank.kind == KIND_MBC2);
      pend_ram_rd <= (op_mode == MODE_RAM_RD) && ram_hit;
      pend_fetch  <= (op_mode == MODE_ROM_RD) && rom_hit;
      pend_addr   <= (op_mode == MODE_ROM_RD && rom_hit) ? rom_r : 23'd0;
      if ((op_mode == MODE_ROM_RD && !rom_hit) || (op_mode == MODE_RAM_RD && !ram_hit)) begin
        pend_data <= 8'hFF;
      end else begin
        pend_data <= 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_ram_rd) begin
        read_data <= pend_mbc2 ? {4'hF, ram_rdata[3:0]} : ram_rdata;
      end else begin
        read_data <= pend_data;
      end
      rom_fetch   <= pend_fetch;
      rom_address <= pend_addr;
      ram_dirty   <= dirty;
    end
  end

endmodule
`default_nettype wire
